FILE: rtl/core/twlpm_pkg.sv
// ----------------------------------------------------------------------------
// twlpm_pkg
// Shared constants for the text word, line and page match scanner.
// ----------------------------------------------------------------------------
package twlpm_pkg;

  localparam int unsigned MAX_QUERY_BYTES_DEF = 8;
  localparam int unsigned COUNT_WIDTH_DEF     = 32;
  localparam int unsigned PAGE_WIDTH_DEF      = 16;

  // configuration register widths and reset values
  localparam int unsigned QUERY_W      = 64;
  localparam int unsigned QLEN_W       = 4;
  localparam int unsigned LPP_W        = 10;
  localparam logic [LPP_W-1:0] LPP_RESET = LPP_W'(50);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CHARS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_PAGE = 2'd2;

  // stream word layouts
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned WORD_TOT_W  = 32;
  localparam int unsigned MATCH_W     = 32;
  localparam int unsigned PAGE_NUM_W  = 16;
  localparam int unsigned OUT_FIELD_W = WORD_TOT_W + MATCH_W + PAGE_NUM_W + 2;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int unsigned WORD_TOT_LSB  = 0;
  localparam int unsigned MATCH_LSB     = WORD_TOT_W;
  localparam int unsigned PAGE_NUM_LSB  = MATCH_LSB + MATCH_W;
  localparam int unsigned LINE_HIT_BIT  = PAGE_NUM_LSB + PAGE_NUM_W;
  localparam int unsigned PAGE_HIT_BIT  = LINE_HIT_BIT + 1;

  // special bytes
  localparam logic [7:0] BYTE_NUL = 8'd0;
  localparam logic [7:0] BYTE_TAB = 8'd9;
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_SP  = 8'd32;

  function automatic logic is_blank(input logic [7:0] b);
    return ((b >= BYTE_TAB) && (b <= BYTE_CR)) || (b == BYTE_SP);
  endfunction

endpackage

FILE: rtl/core/text_word_line_page_match_scanner_unit.sv
// ----------------------------------------------------------------------------
// text_word_line_page_match_scanner_unit
// Streaming word counter, query line matcher and page tracker.
// ----------------------------------------------------------------------------
// One text byte per input word, one result word per input word, at a
// sustained rate of one byte per clock unless out_tready stalls it: the
// byte is scanned by the match and count logic in the accept cycle and the
// result lands in the output register, which is refilled while it is being taken.
// Zero bytes return the current counters and leave all state untouched.
// Write the query and page size over the cfg port only while the stream is
// idle; lines_per_page of zero acts as one.
module text_word_line_page_match_scanner_unit #(
  parameter int unsigned MAX_QUERY_BYTES = twlpm_pkg::MAX_QUERY_BYTES_DEF,
  parameter int unsigned COUNT_WIDTH     = twlpm_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned PAGE_WIDTH      = twlpm_pkg::PAGE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [twlpm_pkg::IN_TDATA_W-1:0]      in_tdata,   // [7:0] data_byte
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [31:0] word_total, [63:32] matched_lines, [79:64] page_number,
  // [80] line_hit, [81] page_hit, [87:82] zero
  output logic [twlpm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [twlpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [twlpm_pkg::QUERY_W-1:0]         cfg_data
);

  localparam int unsigned WIN_W  = 8 * MAX_QUERY_BYTES;
  localparam int unsigned FILL_W = $clog2(MAX_QUERY_BYTES + 1);
  localparam int unsigned CMP_W  = (FILL_W > twlpm_pkg::QLEN_W) ? FILL_W : twlpm_pkg::QLEN_W;
  localparam int unsigned CNT_XW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
  localparam int unsigned PG_XW  = (PAGE_WIDTH > 16) ? PAGE_WIDTH : 16;

  // configuration
  logic [twlpm_pkg::QUERY_W-1:0] query_r;
  logic [twlpm_pkg::QLEN_W-1:0]  qlen_r;
  logic [twlpm_pkg::LPP_W-1:0]   lpp_r;

  // scan state
  logic                         in_word_r,      in_word_nxt;
  logic [WIN_W-1:0]             window_r,       window_nxt;
  logic [FILL_W-1:0]            fill_r,         fill_nxt;
  logic                         line_matched_r, line_matched_nxt;
  logic [twlpm_pkg::LPP_W-1:0]  line_in_page_r, line_in_page_nxt;
  logic [PAGE_WIDTH-1:0]        page_r,         page_nxt;
  logic                         page_rep_r,     page_rep_nxt;
  logic [COUNT_WIDTH-1:0]       word_cnt_r,     word_cnt_nxt;
  logic [COUNT_WIDTH-1:0]       match_cnt_r,    match_cnt_nxt;

  // output register
  logic                               out_valid_r;
  logic [twlpm_pkg::OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;

  logic                   accept;
  logic [7:0]             b;
  logic [CMP_W-1:0]       qlen_eff;
  logic [FILL_W-1:0]      push_fill;
  logic [WIN_W-1:0]       push_win;
  logic                   win_hit;
  logic                   lhit, phit;
  logic [twlpm_pkg::LPP_W:0] line_inc;
  logic [CNT_XW-1:0]      word_x, match_x;
  logic [PG_XW-1:0]       page_x;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign b          = in_tdata[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r <= '0;
      qlen_r  <= '0;
      lpp_r   <= twlpm_pkg::LPP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        twlpm_pkg::CFG_QUERY_CHARS:    query_r <= cfg_data;
        twlpm_pkg::CFG_QUERY_LENGTH:   qlen_r  <= cfg_data[twlpm_pkg::QLEN_W-1:0];
        twlpm_pkg::CFG_LINES_PER_PAGE: lpp_r   <= cfg_data[twlpm_pkg::LPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (CMP_W'(qlen_r) > CMP_W'(MAX_QUERY_BYTES)) qlen_eff = CMP_W'(MAX_QUERY_BYTES);
    else                                          qlen_eff = CMP_W'(qlen_r);

    push_win  = WIN_W'({window_r, b});
    push_fill = (fill_r < FILL_W'(MAX_QUERY_BYTES)) ? fill_r + 1'b1 : fill_r;

    win_hit = (CMP_W'(push_fill) >= qlen_eff);
    for (int i = 0; i < MAX_QUERY_BYTES; i++) begin
      if ((CMP_W'(i) < qlen_eff) && (push_win[8*i +: 8] != query_r[8*i +: 8]))
        win_hit = 1'b0;
    end

    in_word_nxt      = in_word_r;
    window_nxt       = window_r;
    fill_nxt         = fill_r;
    line_matched_nxt = line_matched_r;
    line_in_page_nxt = line_in_page_r;
    page_nxt         = page_r;
    page_rep_nxt     = page_rep_r;
    word_cnt_nxt     = word_cnt_r;
    match_cnt_nxt    = match_cnt_r;
    lhit             = 1'b0;
    phit             = 1'b0;
    line_inc         = {1'b0, line_in_page_r} + 1'b1;

    if (b != twlpm_pkg::BYTE_NUL) begin
      if (twlpm_pkg::is_blank(b)) begin
        in_word_nxt = 1'b0;
      end else if (!in_word_r) begin
        in_word_nxt = 1'b1;
        if (!(&word_cnt_r)) word_cnt_nxt = word_cnt_r + 1'b1;
      end

      window_nxt = push_win;
      fill_nxt   = push_fill;

      if (!line_matched_r && win_hit) begin
        line_matched_nxt = 1'b1;
        lhit             = 1'b1;
        if (!(&match_cnt_r)) match_cnt_nxt = match_cnt_r + 1'b1;
        if (!page_rep_r) begin
          page_rep_nxt = 1'b1;
          phit         = 1'b1;
        end
      end

      if (b == twlpm_pkg::BYTE_LF) begin
        window_nxt       = '0;
        fill_nxt         = '0;
        line_matched_nxt = 1'b0;
        if (line_inc >= {1'b0, lpp_r}) begin
          line_in_page_nxt = '0;
          page_rep_nxt     = 1'b0;
          if (!(&page_r)) page_nxt = page_r + 1'b1;
        end else begin
          line_in_page_nxt = line_inc[twlpm_pkg::LPP_W-1:0];
        end
      end
    end

    word_x  = CNT_XW'(word_cnt_nxt);
    match_x = CNT_XW'(match_cnt_nxt);
    page_x  = PG_XW'(page_r);

    out_data_nxt = '0;
    out_data_nxt[twlpm_pkg::WORD_TOT_LSB +: twlpm_pkg::WORD_TOT_W] =
      word_x[twlpm_pkg::WORD_TOT_W-1:0];
    out_data_nxt[twlpm_pkg::MATCH_LSB +: twlpm_pkg::MATCH_W] =
      match_x[twlpm_pkg::MATCH_W-1:0];
    out_data_nxt[twlpm_pkg::PAGE_NUM_LSB +: twlpm_pkg::PAGE_NUM_W] =
      page_x[twlpm_pkg::PAGE_NUM_W-1:0];
    out_data_nxt[twlpm_pkg::LINE_HIT_BIT] = lhit;
    out_data_nxt[twlpm_pkg::PAGE_HIT_BIT] = phit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r      <= 1'b0;
      window_r       <= '0;
      fill_r         <= '0;
      line_matched_r <= 1'b0;
      line_in_page_r <= '0;
      page_r         <= PAGE_WIDTH'(1);
      page_rep_r     <= 1'b0;
      word_cnt_r     <= '0;
      match_cnt_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        in_word_r      <= in_word_nxt;
        window_r       <= window_nxt;
        fill_r         <= fill_nxt;
        line_matched_r <= line_matched_nxt;
        line_in_page_r <= line_in_page_nxt;
        page_r         <= page_nxt;
        page_rep_r     <= page_rep_nxt;
        word_cnt_r     <= word_cnt_nxt;
        match_cnt_r    <= match_cnt_nxt;
      end
      if (accept)          out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= out_data_nxt;
  end

endmodule

FILE: rtl/core/twlpm_checker.sv
// ----------------------------------------------------------------------------
// twlpm_checker
// Port-level checks for the scanner, bound to the top level.
// ----------------------------------------------------------------------------
module twlpm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [twlpm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [twlpm_pkg::WORD_TOT_W-1:0] word_tot;
  logic [twlpm_pkg::MATCH_W-1:0]    match_tot;
  logic                             line_hit, page_hit;

  assign word_tot  = out_tdata[twlpm_pkg::WORD_TOT_LSB +: twlpm_pkg::WORD_TOT_W];
  assign match_tot = out_tdata[twlpm_pkg::MATCH_LSB +: twlpm_pkg::MATCH_W];
  assign line_hit  = out_tdata[twlpm_pkg::LINE_HIT_BIT];
  assign page_hit  = out_tdata[twlpm_pkg::PAGE_HIT_BIT];

  // every accepted byte shows a result word on the next cycle
  a_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result word after accepted byte");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // first match on a page is always a line match
  a_page_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && page_hit |-> line_hit)
    else $error("page_hit without line_hit");

  // a line hit always carries a nonzero match count
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && line_hit |-> match_tot != '0)
    else $error("line_hit with zero match count");

  // word count never drops between back-to-back results
  a_word_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_tvalid && out_tready ##1 out_tvalid |-> word_tot >= $past(word_tot))
    else $error("word count went backward");

endmodule

bind text_word_line_page_match_scanner_unit twlpm_checker u_twlpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
